[sv/ising_metropolis_spin_update_defines.svh]
// Assertion macros for the Ising spin update RTL.
`ifndef ISING_METROPOLIS_SPIN_UPDATE_DEFINES_SVH
`define ISING_METROPOLIS_SPIN_UPDATE_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled while arst_n is low.
`define ISMU_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk and disabled while arst_n is low.
`define ISMU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/ismu_pkg.sv]
// Shared constants, types and wrap functions for the Ising spin update block.
`default_nettype none

package ismu_pkg;

	// Fixed field widths of the item and result beats.
	localparam int ROW_W   = 6;
	localparam int SIZE_W  = 7;
	localparam int PROB_W  = 16;
	localparam int COUNT_W = 13;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 2;

	// Index arithmetic width, wide enough for a side of 256 and its wrap.
	localparam int IDX_W = 9;

	// Parameter defaults.
	localparam int MAX_SIDE_DEF  = 64;
	localparam int PROB_BITS_DEF = 16;

	// Reset value of the lattice side register.
	localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_LATTICE_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_FOUR  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_EIGHT = 2'd2;

	// Item function codes.
	localparam logic FUNC_LOAD    = 1'b0;
	localparam logic FUNC_ATTEMPT = 1'b1;

	// Status of one finished item.
	typedef struct packed {
		logic               flipped;
		logic [COUNT_W-1:0] down_count;
		logic               out_of_range;
	} result_t;

	// Step one position back with periodic wrap at side n.
	function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] v,
			input logic [IDX_W-1:0] n);
		return (v == '0) ? n - IDX_W'(1) : v - IDX_W'(1);
	endfunction

	// Step one position forward with periodic wrap at side n.
	function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] v,
			input logic [IDX_W-1:0] n);
		return ((v + IDX_W'(1)) >= n) ? '0 : v + IDX_W'(1);
	endfunction

endpackage

`default_nettype wire

[sv/ising_metropolis_spin_update.sv]
// Top level of the Ising spin update block: item register, lattice, decision and results.
// The item is taken into the item register, and done and the result beat are registered from it.
// Throughput: one item per cycle; busy stays low and the result beat cannot be held off.
// The pace is set by one row read per lattice copy per cycle, with the row written
// in the same cycle forwarded to the next item.
// Reset: all spins up (row valid bits cleared), count zero, size 64, thresholds zero.
`default_nettype none
`include "ising_metropolis_spin_update_defines.svh"

module ising_metropolis_spin_update #(
	parameter int MAX_SIDE  = ismu_pkg::MAX_SIDE_DEF,
	parameter int PROB_BITS = ismu_pkg::PROB_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic                            func,
	input  wire logic [ismu_pkg::ROW_W-1:0]      row,
	input  wire logic [ismu_pkg::ROW_W-1:0]      column,
	input  wire logic                            spin_down,
	input  wire logic [ismu_pkg::PROB_W-1:0]     random_word,
	input  wire logic                            cfg_write,
	input  wire logic [ismu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ismu_pkg::CFG_W-1:0]      cfg_data,
	output logic                                 done,
	output logic                                 flipped,
	output logic      [ismu_pkg::COUNT_W-1:0]    down_count,
	output logic                                 out_of_range
);

	localparam int AW = $clog2(MAX_SIDE);

	logic [ismu_pkg::SIZE_W-1:0]  lattice_size_q;
	logic [ismu_pkg::PROB_W-1:0]  accept_four_q;
	logic [ismu_pkg::PROB_W-1:0]  accept_eight_q;
	logic [ismu_pkg::IDX_W-1:0]   side;
	logic [ismu_pkg::IDX_W-1:0]   size_x;
	logic [ismu_pkg::IDX_W-1:0]   row_x;
	logic [AW-1:0]                raddr_site;
	logic [AW-1:0]                raddr_up;
	logic [AW-1:0]                raddr_dn;
	logic                         accept;

	logic                         valid_s1;
	logic                         func_s1;
	logic [ismu_pkg::ROW_W-1:0]   row_s1;
	logic [ismu_pkg::ROW_W-1:0]   column_s1;
	logic                         spin_down_s1;
	logic [ismu_pkg::PROB_W-1:0]  random_s1;

	logic [MAX_SIDE-1:0]          site_row;
	logic [MAX_SIDE-1:0]          up_row;
	logic [MAX_SIDE-1:0]          dn_row;
	logic                         wr_en;
	logic [MAX_SIDE-1:0]          wr_row;
	logic [ismu_pkg::COUNT_W-1:0] next_total;
	logic [ismu_pkg::COUNT_W-1:0] down_total_q;
	ismu_pkg::result_t            res_s1;
	ismu_pkg::result_t            res_q;
	logic                         done_q;

	// The block takes an item in every cycle.
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lattice_size_q <= ismu_pkg::SIZE_RESET;
			accept_four_q  <= '0;
			accept_eight_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				ismu_pkg::REG_LATTICE_SIZE: begin
					lattice_size_q <= cfg_data[ismu_pkg::SIZE_W-1:0];
				end
				ismu_pkg::REG_ACCEPT_FOUR: begin
					accept_four_q <= cfg_data[ismu_pkg::PROB_W-1:0];
				end
				ismu_pkg::REG_ACCEPT_EIGHT: begin
					accept_eight_q <= cfg_data[ismu_pkg::PROB_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Side in use, clamped to the lattice store.
	always_comb begin
		size_x = ismu_pkg::IDX_W'(lattice_size_q);
		if (size_x < ismu_pkg::IDX_W'(2)) begin
			side = ismu_pkg::IDX_W'(2);
		end else if (size_x > ismu_pkg::IDX_W'(MAX_SIDE)) begin
			side = ismu_pkg::IDX_W'(MAX_SIDE);
		end else begin
			side = size_x;
		end
	end

	// Rows to read for the incoming item: its own and the two diagonal rows.
	always_comb begin
		row_x      = ismu_pkg::IDX_W'(row);
		raddr_site = AW'(row_x);
		raddr_up   = AW'(ismu_pkg::wrap_dec(row_x, side));
		raddr_dn   = AW'(ismu_pkg::wrap_inc(row_x, side));
	end

	// Item register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		func_s1      <= func;
		row_s1       <= row;
		column_s1    <= column;
		spin_down_s1 <= spin_down;
		random_s1    <= random_word;
	end

	ismu_lattice #(
		.MAX_SIDE (MAX_SIDE)
	) u_lattice (
		.clk        (clk),
		.arst_n     (arst_n),
		.raddr_site (raddr_site),
		.raddr_up   (raddr_up),
		.raddr_dn   (raddr_dn),
		.wr_en      (wr_en),
		.wr_addr    (AW'(row_s1)),
		.wr_row     (wr_row),
		.site_row   (site_row),
		.up_row     (up_row),
		.dn_row     (dn_row)
	);

	ismu_update #(
		.MAX_SIDE  (MAX_SIDE),
		.PROB_BITS (PROB_BITS)
	) u_update (
		.item_valid  (valid_s1),
		.func        (func_s1),
		.row         (row_s1),
		.column      (column_s1),
		.spin_down   (spin_down_s1),
		.random_word (random_s1),
		.side        (side),
		.thr_four    (accept_four_q),
		.thr_eight   (accept_eight_q),
		.site_row    (site_row),
		.up_row      (up_row),
		.dn_row      (dn_row),
		.total       (down_total_q),
		.wr_en       (wr_en),
		.wr_row      (wr_row),
		.next_total  (next_total),
		.res         (res_s1)
	);

	// Running count and the result beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			down_total_q <= '0;
			done_q       <= 1'b0;
		end else begin
			down_total_q <= next_total;
			done_q       <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_s1;
	end

	assign done         = done_q;
	assign flipped      = res_q.flipped;
	assign down_count   = res_q.down_count;
	assign out_of_range = res_q.out_of_range;

	// An ignored site leaves the count alone.
	`ISMU_ASSERT_NEXT(a_oor_keeps_count, valid_s1 && res_s1.out_of_range, down_total_q == $past(down_total_q), "out-of-range item changed the down count")
	// A flip moves the count by exactly one.
	`ISMU_ASSERT_NEXT(a_flip_steps_count, valid_s1 && res_s1.flipped, (down_total_q == $past(down_total_q) + ismu_pkg::COUNT_W'(1)) || (down_total_q == $past(down_total_q) - ismu_pkg::COUNT_W'(1)), "flip did not step the down count by one")
	// Every result beat comes from an item taken through the item register.
	`ISMU_ASSERT_SAME(a_done_has_item, done_q, $past(accept, 2), "result beat without an accepted item")
	// A flagged site never reports a flip.
	`ISMU_ASSERT_SAME(a_oor_no_flip, done_q && res_q.out_of_range, !res_q.flipped, "out-of-range result reports a flip")

endmodule

`default_nettype wire

[sv/ismu_row_ram.sv]
// One copy of the spin lattice, a row per word, with a registered read port.
`default_nettype none

module ismu_row_ram #(
	parameter int DEPTH = ismu_pkg::MAX_SIDE_DEF,
	parameter int AW    = 6,
	parameter int DW    = ismu_pkg::MAX_SIDE_DEF
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	// Single write port and single registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[sv/ismu_lattice.sv]
// Spin lattice: three row copies, row valid bits and forwarding of the last write.
`default_nettype none

module ismu_lattice #(
	parameter int MAX_SIDE = ismu_pkg::MAX_SIDE_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [$clog2(MAX_SIDE)-1:0]   raddr_site,
	input  wire logic [$clog2(MAX_SIDE)-1:0]   raddr_up,
	input  wire logic [$clog2(MAX_SIDE)-1:0]   raddr_dn,
	input  wire logic                          wr_en,
	input  wire logic [$clog2(MAX_SIDE)-1:0]   wr_addr,
	input  wire logic [MAX_SIDE-1:0]           wr_row,
	output logic      [MAX_SIDE-1:0]           site_row,
	output logic      [MAX_SIDE-1:0]           up_row,
	output logic      [MAX_SIDE-1:0]           dn_row
);

	localparam int AW = $clog2(MAX_SIDE);
	localparam int NPORT = 3;

	logic [MAX_SIDE-1:0] row_valid_q;
	logic                fwd_en_q;
	logic [AW-1:0]       fwd_addr_q;
	logic [MAX_SIDE-1:0] fwd_row_q;

	logic [AW-1:0]       raddr      [NPORT];
	logic [AW-1:0]       raddr_s1   [NPORT];
	logic                rvalid_s1  [NPORT];
	logic [MAX_SIDE-1:0] ram_data   [NPORT];
	logic [MAX_SIDE-1:0] row_out    [NPORT];

	assign raddr[0] = raddr_site;
	assign raddr[1] = raddr_up;
	assign raddr[2] = raddr_dn;

	// A row that was never written reads as all spins up.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			fwd_en_q    <= 1'b0;
		end else begin
			fwd_en_q <= wr_en;
			if (wr_en) begin
				row_valid_q[wr_addr] <= 1'b1;
			end
		end
	end

	// The last written row is kept to patch reads taken at the same edge.
	always_ff @(posedge clk) begin
		fwd_addr_q <= wr_addr;
		fwd_row_q  <= wr_row;
	end

	for (genvar g = 0; g < NPORT; g++) begin : g_port
		ismu_row_ram #(
			.DEPTH (MAX_SIDE),
			.AW    (AW),
			.DW    (MAX_SIDE)
		) u_ram (
			.clk   (clk),
			.we    (wr_en),
			.waddr (wr_addr),
			.wdata (wr_row),
			.raddr (raddr[g]),
			.rdata (ram_data[g])
		);

		// Address and valid bit travel with the read data.
		always_ff @(posedge clk) begin
			raddr_s1[g]  <= raddr[g];
			rvalid_s1[g] <= row_valid_q[raddr[g]];
		end

		// Forwarded row wins, then stored row, then the reset value.
		always_comb begin
			if (fwd_en_q && (fwd_addr_q == raddr_s1[g])) begin
				row_out[g] = fwd_row_q;
			end else if (rvalid_s1[g]) begin
				row_out[g] = ram_data[g];
			end else begin
				row_out[g] = '0;
			end
		end
	end

	assign site_row = row_out[0];
	assign up_row   = row_out[1];
	assign dn_row   = row_out[2];

endmodule

`default_nettype wire

[sv/ismu_update.sv]
// Metropolis decision, row rewrite and down-spin count for the item in stage one.
`default_nettype none

module ismu_update #(
	parameter int MAX_SIDE  = ismu_pkg::MAX_SIDE_DEF,
	parameter int PROB_BITS = ismu_pkg::PROB_BITS_DEF
) (
	input  wire logic                          item_valid,
	input  wire logic                          func,
	input  wire logic [ismu_pkg::ROW_W-1:0]    row,
	input  wire logic [ismu_pkg::ROW_W-1:0]    column,
	input  wire logic                          spin_down,
	input  wire logic [ismu_pkg::PROB_W-1:0]   random_word,
	input  wire logic [ismu_pkg::IDX_W-1:0]    side,
	input  wire logic [ismu_pkg::PROB_W-1:0]   thr_four,
	input  wire logic [ismu_pkg::PROB_W-1:0]   thr_eight,
	input  wire logic [MAX_SIDE-1:0]           site_row,
	input  wire logic [MAX_SIDE-1:0]           up_row,
	input  wire logic [MAX_SIDE-1:0]           dn_row,
	input  wire logic [ismu_pkg::COUNT_W-1:0]  total,
	output logic                               wr_en,
	output logic      [MAX_SIDE-1:0]           wr_row,
	output logic      [ismu_pkg::COUNT_W-1:0]  next_total,
	output ismu_pkg::result_t                  res
);

	localparam int AW = $clog2(MAX_SIDE);
	localparam int PW = (PROB_BITS < ismu_pkg::PROB_W) ? PROB_BITS : ismu_pkg::PROB_W;

	logic [ismu_pkg::IDX_W-1:0] row_x;
	logic [ismu_pkg::IDX_W-1:0] col_x;
	logic [AW-1:0]              col_i;
	logic [AW-1:0]              col_m;
	logic [AW-1:0]              col_p;
	logic                       oor;
	logic                       site;
	logic [3:0]                 agree_vec;
	logic [2:0]                 agree_cnt;
	logic                       win_four;
	logic                       win_eight;
	logic                       flip;
	logic                       new_bit;
	logic                       change_req;

	// Site bounds and the columns of the diagonal neighbors.
	always_comb begin
		row_x = ismu_pkg::IDX_W'(row);
		col_x = ismu_pkg::IDX_W'(column);
		oor   = (row_x >= side) || (col_x >= side);
		col_i = AW'(col_x);
		col_m = AW'(ismu_pkg::wrap_dec(col_x, side));
		col_p = AW'(ismu_pkg::wrap_inc(col_x, side));
	end

	// Count diagonal neighbors that agree with the site.
	always_comb begin
		site      = site_row[col_i];
		agree_vec = {up_row[col_m] == site, up_row[col_p] == site,
			dn_row[col_m] == site, dn_row[col_p] == site};
		agree_cnt = 3'(agree_vec[0]) + 3'(agree_vec[1]) + 3'(agree_vec[2])
			+ 3'(agree_vec[3]);
	end

	// Acceptance test against the thresholds for energy eight and four.
	always_comb begin
		win_eight = thr_eight[PW-1:0] > random_word[PW-1:0];
		win_four  = thr_four[PW-1:0] > random_word[PW-1:0];
		priority if (agree_cnt == 3'd4) begin
			flip = win_eight;
		end else if (agree_cnt == 3'd3) begin
			flip = win_four;
		end else begin
			flip = 1'b1;
		end
	end

	// New spin value, row rewrite and running count.
	always_comb begin
		if (func == ismu_pkg::FUNC_LOAD) begin
			new_bit    = spin_down;
			change_req = 1'b1;
		end else begin
			new_bit    = ~site;
			change_req = flip;
		end
		wr_en         = item_valid & ~oor & change_req;
		wr_row        = site_row;
		wr_row[col_i] = new_bit;
		next_total    = total;
		if (wr_en && (new_bit != site)) begin
			next_total = new_bit ? total + ismu_pkg::COUNT_W'(1)
				: total - ismu_pkg::COUNT_W'(1);
		end
		res.flipped      = item_valid & ~oor & (func == ismu_pkg::FUNC_ATTEMPT) & flip;
		res.down_count   = next_total;
		res.out_of_range = oor;
	end

endmodule

`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for the Ising spin update block, run against a local lattice model.
`timescale 1ns / 1ps

module tb_top;
	import ismu_pkg::*;

	localparam int SIDE = MAX_SIDE_DEF;

	// One item beat as it goes onto the input ports.
	typedef struct packed {
		logic              func;
		logic [ROW_W-1:0]  row;
		logic [ROW_W-1:0]  column;
		logic              spin_down;
		logic [PROB_W-1:0] random_word;
	} spin_item_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic                 func = FUNC_LOAD;
	logic [ROW_W-1:0]     row = '0;
	logic [ROW_W-1:0]     column = '0;
	logic                 spin_down = 1'b0;
	logic [PROB_W-1:0]    random_word = '0;
	logic                 cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_LATTICE_SIZE;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 done;
	logic                 flipped;
	logic [COUNT_W-1:0]   down_count;
	logic                 out_of_range;

	// Local copy of the lattice, the down count and the registers.
	logic                 spin_model [0:SIDE*SIDE-1];
	logic [COUNT_W-1:0]   down_spins = '0;
	logic [SIZE_W-1:0]    side_reg = SIZE_RESET;
	logic [PROB_W-1:0]    thr_four = '0;
	logic [PROB_W-1:0]    thr_eight = '0;

	spin_item_t item_backlog [$];
	result_t    predicted_results [$];
	int         fail_count = 0;
	int         gap_left = 0;
	logic       steady_phase = 1'b0;

	logic [SIZE_W-1:0] phase_sides [0:9] = '{7'd64, 7'd2, 7'd0, 7'd7, 7'd127,
		7'd1, 7'd64, 7'd33, 7'd65, 7'd3};

	ising_metropolis_spin_update i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.row          (row),
		.column       (column),
		.spin_down    (spin_down),
		.random_word  (random_word),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.done         (done),
		.flipped      (flipped),
		.down_count   (down_count),
		.out_of_range (out_of_range)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		foreach (spin_model[i]) spin_model[i] = 1'b0;
	end

	// The side in use is the register clamped to 2..SIDE.
	function automatic int eff_side();
		int n;
		n = side_reg;
		if (n < 2) n = 2;
		if (n > SIDE) n = SIDE;
		return n;
	endfunction

	// Write one spin and keep the down count over the whole store.
	function automatic void store_spin(input int r, input int c, input logic v);
		if (spin_model[r*SIDE+c] != v) begin
			spin_model[r*SIDE+c] = v;
			down_spins = v ? down_spins + 1'b1 : down_spins - 1'b1;
		end
	endfunction

	// Apply one item to the local lattice and return the result it should give.
	function automatic result_t apply_item(input spin_item_t it);
		result_t res;
		int n, r, c, rm, rp, cm, cp, agree;
		logic site, flip;
		res = '0;
		n = eff_side();
		r = it.row;
		c = it.column;
		if (r >= n || c >= n) begin
			res.out_of_range = 1'b1;
		end else if (it.func == FUNC_LOAD) begin
			store_spin(r, c, it.spin_down);
		end else begin
			site = spin_model[r*SIDE+c];
			rm = (r == 0) ? n - 1 : r - 1;
			rp = (r + 1 >= n) ? 0 : r + 1;
			cm = (c == 0) ? n - 1 : c - 1;
			cp = (c + 1 >= n) ? 0 : c + 1;
			// The coupling uses the four diagonal neighbors.
			agree = int'(spin_model[rm*SIDE+cm] == site) + int'(spin_model[rm*SIDE+cp] == site)
				+ int'(spin_model[rp*SIDE+cm] == site) + int'(spin_model[rp*SIDE+cp] == site);
			if (agree == 4)
				flip = thr_eight > it.random_word;
			else if (agree == 3)
				flip = thr_four > it.random_word;
			else
				flip = 1'b1;
			if (flip) begin
				store_spin(r, c, ~site);
				res.flipped = 1'b1;
			end
		end
		res.down_count = down_spins;
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady_phase || r < 65) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Random words lean toward the thresholds so that both sides of each compare are hit.
	function automatic logic [PROB_W-1:0] pick_word();
		case ($urandom_range(0, 7))
			0: return thr_four;
			1: return thr_eight;
			2: return thr_four - 1'b1;
			3: return thr_eight - 1'b1;
			default: return PROB_W'($urandom);
		endcase
	endfunction

	function automatic void add_item(input logic f, input int r, input int c, input logic sd,
			input logic [PROB_W-1:0] w);
		spin_item_t it;
		it.func = f;
		it.row = ROW_W'(r);
		it.column = ROW_W'(c);
		it.spin_down = sd;
		it.random_word = w;
		item_backlog.push_back(it);
	endfunction

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10) $display("%0t ns: %s", $time, msg);
	endtask

	// Wait until every item is sent and every result is back; checked between edges.
	task automatic wait_idle();
		@(negedge clk);
		while (item_backlog.size() != 0 || start || predicted_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_LATTICE_SIZE: side_reg = val[SIZE_W-1:0];
			REG_ACCEPT_FOUR:  thr_four = val[PROB_W-1:0];
			REG_ACCEPT_EIGHT: thr_eight = val[PROB_W-1:0];
			default: ;
		endcase
	endtask

	// Driver: predict each accepted beat, then present the next item or idle with noise.
	always @(posedge clk) begin
		spin_item_t nxt;
		logic took;
		if (arst_n) begin
			took = start && !busy;
			if (took) begin
				nxt.func = func;
				nxt.row = row;
				nxt.column = column;
				nxt.spin_down = spin_down;
				nxt.random_word = random_word;
				predicted_results.push_back(apply_item(nxt));
				gap_left = pick_gap();
			end
			if (start && !took) begin
				// Hold the item until it is taken.
			end else if (gap_left == 0 && item_backlog.size() != 0) begin
				nxt = item_backlog.pop_front();
				start <= 1'b1;
				func <= nxt.func;
				row <= nxt.row;
				column <= nxt.column;
				spin_down <= nxt.spin_down;
				random_word <= nxt.random_word;
			end else begin
				if (gap_left > 0) gap_left--;
				start <= 1'b0;
				func <= 1'($urandom);
				row <= ROW_W'($urandom);
				column <= ROW_W'($urandom);
				spin_down <= 1'($urandom);
				random_word <= PROB_W'($urandom);
			end
		end
	end

	// Monitor: every result beat is matched against the oldest prediction.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (predicted_results.size() == 0) begin
				note_failure($sformatf("unexpected result: flipped %0d down_count %0d oor %0d",
					flipped, down_count, out_of_range));
			end else begin
				want = predicted_results.pop_front();
				if (flipped !== want.flipped || down_count !== want.down_count
						|| out_of_range !== want.out_of_range)
					note_failure($sformatf({"result mismatch: flipped %0d/%0d ",
						"down_count %0d/%0d oor %0d/%0d (expected/actual)"},
						want.flipped, flipped, want.down_count, down_count,
						want.out_of_range, out_of_range));
			end
		end
	end

	initial begin
		int n, pick;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: full lattice, zero thresholds, so agreeing sites never flip.
		add_item(FUNC_ATTEMPT, 10, 10, 1'b1, 16'h0000);
		add_item(FUNC_LOAD, 9, 9, 1'b1, 16'hFFFF);
		add_item(FUNC_ATTEMPT, 10, 10, 1'b0, 16'h0000);
		add_item(FUNC_LOAD, 11, 11, 1'b1, 16'h0000);
		add_item(FUNC_ATTEMPT, 10, 10, 1'b0, 16'hFFFF);
		add_item(FUNC_LOAD, 0, 0, 1'b1, 16'h0000);
		add_item(FUNC_LOAD, 0, 0, 1'b1, 16'h0000);
		add_item(FUNC_LOAD, 63, 63, 1'b1, 16'h0000);
		add_item(FUNC_LOAD, 0, 63, 1'b1, 16'h0000);
		add_item(FUNC_LOAD, 63, 0, 1'b1, 16'h0000);
		add_item(FUNC_ATTEMPT, 0, 0, 1'b1, 16'hFFFF);
		add_item(FUNC_ATTEMPT, 63, 63, 1'b0, 16'h0000);
		add_item(FUNC_LOAD, 63, 0, 1'b0, 16'h0000);
		wait_idle();

		// Shrunk lattice: sites past the edge are rejected, spins stored there stay counted.
		write_reg(REG_LATTICE_SIZE, 16'd5);
		write_reg(REG_ACCEPT_FOUR, 16'hFFFF);
		write_reg(REG_ACCEPT_EIGHT, 16'h8000);
		add_item(FUNC_ATTEMPT, 5, 0, 1'b0, 16'h0000);
		add_item(FUNC_ATTEMPT, 0, 5, 1'b0, 16'h0000);
		add_item(FUNC_LOAD, 6, 2, 1'b1, 16'h0000);
		add_item(FUNC_ATTEMPT, 2, 2, 1'b0, 16'hFFFF);
		add_item(FUNC_ATTEMPT, 2, 2, 1'b0, 16'h7FFF);
		add_item(FUNC_ATTEMPT, 2, 2, 1'b0, 16'h8000);
		add_item(FUNC_LOAD, 1, 1, 1'b1, 16'h0000);
		add_item(FUNC_ATTEMPT, 2, 2, 1'b0, 16'hFFFF);
		add_item(FUNC_ATTEMPT, 2, 2, 1'b0, 16'hFFFE);
		add_item(FUNC_ATTEMPT, 4, 4, 1'b0, 16'h0000);

		// Random phases, each under its own side and thresholds.
		for (int ph = 0; ph < 10; ph++) begin
			wait_idle();
			write_reg(REG_LATTICE_SIZE, {9'($urandom), phase_sides[ph]});
			write_reg(REG_ACCEPT_FOUR, (ph % 3 == 0) ? 16'hFFFF :
				(ph % 3 == 1) ? 16'h0000 : CFG_W'($urandom));
			write_reg(REG_ACCEPT_EIGHT, (ph % 3 == 0) ? 16'h0000 :
				(ph % 3 == 1) ? 16'hFFFF : CFG_W'($urandom));
			steady_phase = (ph % 3 == 2);
			n = eff_side();
			for (int k = 0; k < 155; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 25)
					add_item(FUNC_LOAD, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
						1'($urandom), PROB_W'($urandom));
				else if (pick < 90)
					add_item(FUNC_ATTEMPT, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
						1'($urandom), pick_word());
				else
					add_item(1'($urandom), $urandom_range(0, 63), $urandom_range(0, 63),
						1'($urandom), PROB_W'($urandom));
			end
		end

		wait_idle();
		repeat (4) @(posedge clk);
		if (fail_count == 0 && predicted_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Run limit, far above the slowest correct run.
	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

[ising_metropolis_spin_update.f]
+incdir+sv
sv/ismu_pkg.sv
sv/ismu_row_ram.sv
sv/ismu_lattice.sv
sv/ismu_update.sv
sv/ising_metropolis_spin_update.sv
test/tb_top.sv
